[rtl/dqs_pkg.sv]
`timescale 1ns / 1ps

package dqs_pkg;

  // Field widths of the request and response words
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SEARCH     = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Strobes from the sequencer to the entry store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[rtl/dqs_if.sv]
`timescale 1ns / 1ps

interface dqs_req_if;
  logic                                valid;
  logic                                ready;
  logic        [dqs_pkg::OPCODE_W-1:0] opcode;
  logic signed [dqs_pkg::VALUE_W-1:0]  value;

  modport source (output valid, opcode, value, input ready);
  modport sink (input valid, opcode, value, output ready);
endinterface

interface dqs_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [dqs_pkg::STATUS_W-1:0] status;
  logic signed [dqs_pkg::VALUE_W-1:0]  read_value;
  logic        [dqs_pkg::POS_W-1:0]    found_position;

  modport source (output valid, status, read_value, found_position, input ready);
  modport sink (input valid, status, read_value, found_position, output ready);
endinterface

[rtl/dqs_store.sv]
`timescale 1ns / 1ps

module dqs_store #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  dqs_pkg::mem_ctl_t                  ctl,
  input  logic        [AW-1:0]               addr,
  input  logic signed [dqs_pkg::VALUE_W-1:0] wr_data,
  output logic signed [dqs_pkg::VALUE_W-1:0] rd_data
);

  logic signed [dqs_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

[rtl/dqs_ctrl.sv]
`timescale 1ns / 1ps

module dqs_ctrl #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  dqs_req_if.sink                            req,
  dqs_rsp_if.source                          rsp,
  output dqs_pkg::mem_ctl_t                  mem_ctl,
  output logic        [AW-1:0]               mem_addr,
  output logic signed [dqs_pkg::VALUE_W-1:0] mem_wdata,
  input  logic signed [dqs_pkg::VALUE_W-1:0] mem_rdata
);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);

  dqs_pkg::state_t state, state_next;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] scan_ptr, scan_ptr_next;
  logic [CW-1:0] cmp_idx, cmp_idx_next;

  logic        [dqs_pkg::OPCODE_W-1:0] op;
  logic signed [dqs_pkg::VALUE_W-1:0]  val;

  dqs_pkg::status_t                   res_status, res_status_next;
  logic signed [dqs_pkg::VALUE_W-1:0] res_rd, res_rd_next;
  logic        [dqs_pkg::POS_W-1:0]   res_pos, res_pos_next;

  logic                                out_valid;
  logic        [dqs_pkg::STATUS_W-1:0] out_status;
  logic signed [dqs_pkg::VALUE_W-1:0]  out_rd;
  logic        [dqs_pkg::POS_W-1:0]    out_pos;

  logic          out_load;
  logic          hit;
  logic [CW-1:0] count_m1;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] scan_inc;

  // Slot that lies off entries past head, off at most DEPTH
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  assign head_inc = ptr_inc(head);
  assign head_dec = (head == '0) ? LAST_SLOT : head - AW'(1);
  assign scan_inc = ptr_inc(scan_ptr);
  assign count_m1 = count - CW'(1);
  assign hit      = (mem_rdata == val);
  assign out_load = (state == dqs_pkg::ST_DONE) && (!out_valid || rsp.ready);

  assign req.ready          = (state == dqs_pkg::ST_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.read_value     = out_rd;
  assign rsp.found_position = out_pos;
  assign mem_wdata          = val;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dqs_pkg::ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op  <= req.opcode;
      val <= req.value;
    end
    scan_ptr   <= scan_ptr_next;
    cmp_idx    <= cmp_idx_next;
    res_status <= res_status_next;
    res_rd     <= res_rd_next;
    res_pos    <= res_pos_next;
    if (out_load) begin
      out_status <= res_status;
      out_rd     <= res_rd;
      out_pos    <= res_pos;
    end
  end

  // Sequencer: decode, memory access, pop finish and front-to-back scan
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    scan_ptr_next   = scan_ptr;
    cmp_idx_next    = cmp_idx;
    res_status_next = res_status;
    res_rd_next     = res_rd;
    res_pos_next    = res_pos;
    mem_ctl         = '0;
    mem_addr        = head;

    unique case (state)
      dqs_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = dqs_pkg::ST_EXEC;
        end
      end

      dqs_pkg::ST_EXEC: begin
        res_status_next = dqs_pkg::STAT_OK;
        res_rd_next     = '0;
        res_pos_next    = '0;
        state_next      = dqs_pkg::ST_DONE;
        unique case (dqs_pkg::opcode_t'(op))
          dqs_pkg::OP_PUSH_FRONT: begin
            if (count == FULL) begin
              res_status_next = dqs_pkg::STAT_OVERFLOW;
            end else begin
              mem_addr      = head_dec;
              mem_ctl.wr_en = 1'b1;
              head_next     = head_dec;
              count_next    = count + CW'(1);
            end
          end
          dqs_pkg::OP_PUSH_BACK: begin
            if (count == FULL) begin
              res_status_next = dqs_pkg::STAT_OVERFLOW;
            end else begin
              mem_addr      = slot_at(head, count);
              mem_ctl.wr_en = 1'b1;
              count_next    = count + CW'(1);
            end
          end
          dqs_pkg::OP_POP_FRONT: begin
            if (count == '0) begin
              res_status_next = dqs_pkg::STAT_EMPTY;
            end else begin
              mem_addr      = head;
              mem_ctl.rd_en = 1'b1;
              state_next    = dqs_pkg::ST_POP;
            end
          end
          dqs_pkg::OP_POP_BACK: begin
            if (count == '0) begin
              res_status_next = dqs_pkg::STAT_EMPTY;
            end else begin
              mem_addr      = slot_at(head, count_m1);
              mem_ctl.rd_en = 1'b1;
              state_next    = dqs_pkg::ST_POP;
            end
          end
          dqs_pkg::OP_SEARCH: begin
            if (count == '0) begin
              res_status_next = dqs_pkg::STAT_EMPTY;
            end else begin
              mem_addr      = head;
              mem_ctl.rd_en = 1'b1;
              scan_ptr_next = head_inc;
              cmp_idx_next  = '0;
              state_next    = dqs_pkg::ST_SCAN;
            end
          end
          default: begin
            // unused opcodes: leave state alone, answer ok with zeros
          end
        endcase
      end

      dqs_pkg::ST_POP: begin
        res_rd_next = mem_rdata;
        count_next  = count_m1;
        if (count_m1 == '0) begin
          head_next = '0;
        end else if (op == dqs_pkg::OP_POP_FRONT) begin
          head_next = head_inc;
        end
        state_next = dqs_pkg::ST_DONE;
      end

      dqs_pkg::ST_SCAN: begin
        // compare the entry read last cycle, fetch the next one
        mem_addr      = scan_ptr;
        mem_ctl.rd_en = 1'b1;
        scan_ptr_next = scan_inc;
        cmp_idx_next  = cmp_idx + CW'(1);
        if (hit) begin
          res_status_next = dqs_pkg::STAT_OK;
          res_pos_next    = dqs_pkg::POS_W'(cmp_idx);
          state_next      = dqs_pkg::ST_DONE;
        end else if (cmp_idx == count_m1) begin
          res_status_next = dqs_pkg::STAT_NOT_FOUND;
          state_next      = dqs_pkg::ST_DONE;
        end
      end

      dqs_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = dqs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dqs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/deque_with_search_core.sv]
`timescale 1ns / 1ps
// A request passes through the execute and done states; a pop adds a pop state unless the
// queue is empty, and a search scans from the front until the first match or the last entry.
// One request at a time; the next is taken the cycle after the response is loaded.
// Synchronous active-high reset empties the queue and clears the head pointer;
// the entry store itself is not cleared.

module deque_with_search_core #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  dqs_req_if.sink    req,
  dqs_rsp_if.source  rsp
);

  localparam int AW = $clog2(DEPTH);

  dqs_pkg::mem_ctl_t                  mem_ctl;
  logic        [AW-1:0]               mem_addr;
  logic signed [dqs_pkg::VALUE_W-1:0] mem_wdata;
  logic signed [dqs_pkg::VALUE_W-1:0] mem_rdata;

  dqs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  dqs_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

endmodule

[rtl/dqs_check.sv]
`timescale 1ns / 1ps

module dqs_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic        [dqs_pkg::STATUS_W-1:0] rsp_status,
  input logic signed [dqs_pkg::VALUE_W-1:0]  rsp_read_value,
  input logic        [dqs_pkg::POS_W-1:0]    rsp_found_position
);

  // Stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_read_value) && $stable(rsp_found_position))
    else $error("stalled response word changed");

  // Reset leaves the block ready with no response pending
  a_reset: assert property (@(posedge clk) rst |=> req_ready && !rsp_valid)
    else $error("bad state after reset");

  // One request at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // A popped word only comes with ok status
  a_rd_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_read_value != '0 |-> rsp_status == dqs_pkg::STAT_OK)
    else $error("read value on failed request");

  // A match position only comes with ok status
  a_pos_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found_position != '0 |-> rsp_status == dqs_pkg::STAT_OK)
    else $error("position on failed request");

endmodule

bind deque_with_search_core dqs_check u_dqs_check (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_read_value     (rsp.read_value),
  .rsp_found_position (rsp.found_position)
);

[tb/tb_deque_with_search_core.sv]
`timescale 1ns / 1ps

// Response fields as the deque is expected to return them
typedef struct packed {
  dqs_pkg::status_t                   status;
  logic signed [dqs_pkg::VALUE_W-1:0] read_value;
  logic        [dqs_pkg::POS_W-1:0]   position;
} deque_reply_t;

// Tracks the deque contents and the responses still owed by the block
class deque_scoreboard #(int DEPTH = 64);
  logic signed [dqs_pkg::VALUE_W-1:0] slots [DEPTH];
  int unsigned                        head;
  int unsigned                        fill;
  deque_reply_t                       owed [$];
  int                                 mismatches;
  int                                 requests;
  int                                 responses;
  int                                 overflows;
  int                                 underflows;
  int                                 hits;
  int                                 misses;
  int                                 ignored;
  int                                 deepest_hit;

  function new();
    head        = 0;
    fill        = 0;
    mismatches  = 0;
    requests    = 0;
    responses   = 0;
    overflows   = 0;
    underflows  = 0;
    hits        = 0;
    misses      = 0;
    ignored     = 0;
    deepest_hit = 0;
  endfunction

  function int unsigned slot(int unsigned off);
    return (head + off) % DEPTH;
  endfunction

  // Pick a word that currently sits somewhere in the deque
  function logic signed [dqs_pkg::VALUE_W-1:0] live_word();
    return slots[slot($urandom_range(0, fill - 1))];
  endfunction

  // Apply one accepted request to the shadow deque and queue its reply
  function void note_request(logic [dqs_pkg::OPCODE_W-1:0] op,
                             logic signed [dqs_pkg::VALUE_W-1:0] val);
    deque_reply_t r;
    r.status     = dqs_pkg::STAT_OK;
    r.read_value = '0;
    r.position   = '0;
    requests++;
    case (op)
      dqs_pkg::OP_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          r.status = dqs_pkg::STAT_OVERFLOW;
        end else begin
          head = (head == 0) ? DEPTH - 1 : head - 1;
          slots[head] = val;
          fill++;
        end
      end
      dqs_pkg::OP_PUSH_BACK: begin
        if (fill == DEPTH) begin
          r.status = dqs_pkg::STAT_OVERFLOW;
        end else begin
          slots[slot(fill)] = val;
          fill++;
        end
      end
      dqs_pkg::OP_POP_FRONT: begin
        if (fill == 0) begin
          r.status = dqs_pkg::STAT_EMPTY;
        end else begin
          r.read_value = slots[head];
          fill--;
          head = (fill == 0) ? 0 : slot(1);
        end
      end
      dqs_pkg::OP_POP_BACK: begin
        if (fill == 0) begin
          r.status = dqs_pkg::STAT_EMPTY;
        end else begin
          r.read_value = slots[slot(fill - 1)];
          fill--;
          if (fill == 0) head = 0;
        end
      end
      dqs_pkg::OP_SEARCH: begin
        if (fill == 0) begin
          r.status = dqs_pkg::STAT_EMPTY;
        end else begin
          // first match from the front wins
          r.status = dqs_pkg::STAT_NOT_FOUND;
          for (int i = 0; i < fill; i++) begin
            if (slots[slot(i)] == val) begin
              r.status   = dqs_pkg::STAT_OK;
              r.position = dqs_pkg::POS_W'(i);
              break;
            end
          end
          if (r.status == dqs_pkg::STAT_OK) begin
            hits++;
            if (int'(r.position) > deepest_hit) deepest_hit = r.position;
          end else begin
            misses++;
          end
        end
      end
      default: ignored++;
    endcase
    if (r.status == dqs_pkg::STAT_OVERFLOW) overflows++;
    if (r.status == dqs_pkg::STAT_EMPTY) underflows++;
    owed.push_back(r);
  endfunction

  // Compare one accepted response against the oldest owed reply
  function void check_response(logic [dqs_pkg::STATUS_W-1:0] status,
                               logic signed [dqs_pkg::VALUE_W-1:0] rd,
                               logic [dqs_pkg::POS_W-1:0] pos);
    deque_reply_t e;
    responses++;
    if (owed.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: response word with nothing outstanding: status %0d read_value %0d pos %0d",
                 $time, status, rd, pos);
      return;
    end
    e = owed.pop_front();
    if (e.status !== status || e.read_value !== rd || e.position !== pos) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t: response %0d mismatch: status %0d/%0d read_value %0d/%0d ",
                  "pos %0d/%0d (exp/got)"},
                 $time, responses, e.status, status, e.read_value, rd, e.position, pos);
    end
  endfunction
endclass

module tb_deque_with_search_core;

  localparam int DEPTH        = 64;
  localparam int RANDOM_WORDS = 1780;
  localparam int CALM_WORDS   = 150;
  localparam int SEGMENT      = 120;
  localparam int HOLD_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  logic hold_rsp;
  int   sent_count;
  int   rsp_gap;

  deque_scoreboard #(DEPTH) sb;

  dqs_req_if req_if ();
  dqs_rsp_if rsp_if ();

  deque_with_search_core #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Known values on every input before the first edge
  initial begin
    sb            = new();
    rst           = 1'b1;
    calm          = 1'b0;
    hold_rsp      = 1'b0;
    sent_count    = 0;
    rsp_gap       = 0;
    req_if.valid  = 1'b0;
    req_if.opcode = '0;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
  end

  // Offer one request word and hold it until accepted, then maybe idle
  task automatic send_word(input logic [dqs_pkg::OPCODE_W-1:0] op,
                           input logic signed [dqs_pkg::VALUE_W-1:0] val);
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.value  <= val;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(op, val);
    sent_count++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_if.valid  <= 1'b0;
      req_if.opcode <= dqs_pkg::OPCODE_W'($urandom);
      req_if.value  <= $urandom;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Mix of extremes, small values that repeat, and full-range noise
  function automatic logic signed [dqs_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $urandom_range(0, 7) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Choose the next request; mode 0 fills, 1 drains, 2 stays balanced
  task automatic send_random(input int mode);
    int unsigned roll;
    int unsigned push_lim;
    int unsigned pop_lim;
    roll     = $urandom_range(0, 99);
    push_lim = (mode == 0) ? 70 : (mode == 1) ? 15 : 40;
    pop_lim  = push_lim + ((mode == 0) ? 10 : (mode == 1) ? 65 : 35);
    if (roll < push_lim) begin
      send_word($urandom_range(0, 1) ? dqs_pkg::OP_PUSH_BACK : dqs_pkg::OP_PUSH_FRONT,
                pick_value());
    end else if (roll < pop_lim) begin
      send_word($urandom_range(0, 1) ? dqs_pkg::OP_POP_BACK : dqs_pkg::OP_POP_FRONT,
                $urandom);
    end else if (roll < 98) begin
      if (sb.fill > 0 && $urandom_range(0, 99) < 65)
        send_word(dqs_pkg::OP_SEARCH, sb.live_word());
      else
        send_word(dqs_pkg::OP_SEARCH, pick_value());
    end else begin
      send_word(dqs_pkg::OPCODE_W'($urandom_range(5, 7)), $urandom);
    end
  endtask

  // Response side: check accepted words, stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.status, rsp_if.read_value, rsp_if.found_position);
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        rsp_gap = $urandom_range(0, 7);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Hold off responses for a long stretch so requests back up
  initial begin
    wait (sent_count >= 400);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb_deque_with_search_core: FAIL");
    $finish;
  end

  initial begin
    int guard;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty-queue cases
    send_word(dqs_pkg::OP_POP_FRONT, 32'sd0);
    send_word(dqs_pkg::OP_POP_BACK, 32'sd0);
    send_word(dqs_pkg::OP_SEARCH, 32'sd0);
    // Extremes at both ends, then searches hitting front, back and nothing
    send_word(dqs_pkg::OP_PUSH_BACK, 32'sh7fff_ffff);
    send_word(dqs_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    send_word(dqs_pkg::OP_PUSH_BACK, 32'sd0);
    send_word(dqs_pkg::OP_PUSH_BACK, -32'sd1);
    send_word(dqs_pkg::OP_SEARCH, 32'sh8000_0000);
    send_word(dqs_pkg::OP_SEARCH, -32'sd1);
    send_word(dqs_pkg::OP_SEARCH, 32'sd12345);
    // Undefined opcodes leave the state alone
    send_word(3'd5, 32'sh7fff_ffff);
    send_word(3'd6, 32'sh8000_0000);
    send_word(3'd7, -32'sd1);
    // Drain to empty from both ends, then one pop too many
    send_word(dqs_pkg::OP_POP_FRONT, 32'sd0);
    send_word(dqs_pkg::OP_POP_BACK, 32'sd0);
    send_word(dqs_pkg::OP_POP_FRONT, 32'sd0);
    send_word(dqs_pkg::OP_POP_BACK, 32'sd0);
    send_word(dqs_pkg::OP_POP_BACK, 32'sd0);
    // Push at the front of an empty queue wraps the head
    send_word(dqs_pkg::OP_PUSH_FRONT, 32'sh5a5a_5a5a);
    send_word(dqs_pkg::OP_PUSH_BACK, 32'sha5a5_a5a5);
    send_word(dqs_pkg::OP_SEARCH, 32'sha5a5_a5a5);
    send_word(dqs_pkg::OP_POP_BACK, 32'sd0);
    send_word(dqs_pkg::OP_POP_FRONT, 32'sd0);

    // Random segments alternate fill, drain and balanced traffic
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - CALM_WORDS) calm <= 1'b1;
      send_random((n / SEGMENT) % 3);
    end
    req_if.valid <= 1'b0;

    // Wait for every owed response, then a scan's worth of extra cycles
    guard = 0;
    while (sb.owed.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DEPTH + 16) @(posedge clk);

    $display("covered %0d requests and %0d responses: %0d overflows, %0d underflow/empty, %0d ignored",
             sb.requests, sb.responses, sb.overflows, sb.underflows, sb.ignored);
    $display("searches: %0d hits (deepest position %0d), %0d misses; %0d mismatches, %0d left owed",
             sb.hits, sb.deepest_hit, sb.misses, sb.mismatches, sb.owed.size());
    if (sb.mismatches == 0 && sb.owed.size() == 0) begin
      $display("tb_deque_with_search_core: PASS");
    end else begin
      $display("tb_deque_with_search_core: FAIL");
    end
    $finish;
  end

endmodule
